/* hdl/scfw_pkg.sv */
package scfw_pkg;

  // sync markers, sent in list order at frame start and in reverse order at frame end
  localparam logic [7:0] SYNC_B0 = 8'h1A;
  localparam logic [7:0] SYNC_B1 = 8'hCF;
  localparam logic [7:0] SYNC_B2 = 8'hFC;
  localparam logic [7:0] SYNC_B3 = 8'h1D;

  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] CRC_HI_MASK  = 16'hFF00;
  localparam logic [15:0] CRC_LO_MASK  = 16'h00FF;
  localparam logic [15:0] SEED_RESET   = 16'hFFFF;

  localparam int HEADER_BYTES_DEF = 16;

  // most words one input byte can cause
  localparam int MAX_RES = 7;
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       short_pkt;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] items;
    logic [CNT_W-1:0]   cnt;
  } res_list_t;

  // crc-16-ccitt, msb first, one byte
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* hdl/sync_crc_frame_wrapper.sv */
// channel   | dir | handshake                    | words
// ----------+-----+------------------------------+------------------------------------
// s_axis    | in  | s_axis_tvalid / tready       | packet byte, tlast on final byte
// m_axis    | out | m_axis_tvalid / tready       | framed byte, tlast on closing sync
// cfg       | in  | cfg_valid_i / cfg_ready_o    | crc seed, taken every cycle
//
// one packet byte is taken per cycle, while m_axis is ready, if its results fit in one
// output word; a byte that opens or closes a header or closes a packet causes up to
// seven words, one per cycle from the result buffer while m_axis is ready, and input
// holds off until its last word leaves; bytes pass the input register and the framer.
// reset clears the packet state and loads the seed with ffff; no clearing pass.
// m_axis stalls back up through the buffer to the input register.
module sync_crc_frame_wrapper #(
  parameter int HEADER_BYTES = scfw_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // packet input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // in_last
  // framed output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,   // out_last
  output logic        m_axis_tuser,   // [0] out_short_packet
  // seed register
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import scfw_pkg::*;

  logic [15:0] seed_q;
  in_item_t    in_item;
  in_item_t    cur_item;
  logic        cur_valid;
  logic        load_ok;
  logic        take;
  res_list_t   res;
  res_t        word;

  assign cfg_ready_o = 1'b1;

  // seed only matters at the next crc restart and as the crc of a short packet trailer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SEED_RESET;
    end else if (cfg_valid_i) begin
      seed_q <= cfg_data_i;
    end
  end

  assign in_item = '{s_axis_tdata, s_axis_tlast};
  // byte moves from input register into the framer once the buffer frees up
  assign take    = cur_valid && load_ok;

  scfw_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (cur_valid),
    .take_i  (take),
    .item_o  (cur_item)
  );

  scfw_framer #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_framer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .item_i (cur_item),
    .seed_i (seed_q),
    .res_o  (res)
  );

  scfw_out_buf u_out_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (take),
    .res_i     (res),
    .load_ok_o (load_ok),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .word_o    (word)
  );

  assign m_axis_tdata = word.data;
  assign m_axis_tlast = word.last;
  assign m_axis_tuser = word.short_pkt;

endmodule

/* hdl/scfw_in_stage.sv */
module scfw_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  scfw_pkg::in_item_t  item_i,
  output logic                valid_o,
  input  logic                take_i,
  output scfw_pkg::in_item_t  item_o
);
  import scfw_pkg::*;

  logic     valid_q;
  in_item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

/* hdl/scfw_framer.sv */
module scfw_framer #(
  parameter int HEADER_BYTES = scfw_pkg::HEADER_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  scfw_pkg::in_item_t  item_i,
  input  logic [15:0]         seed_i,
  output scfw_pkg::res_list_t res_o
);
  import scfw_pkg::*;

  localparam int POS_W = $clog2(HEADER_BYTES + 1);
  localparam logic [POS_W-1:0] POS_DATA = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] POS_HLAST = POS_W'(HEADER_BYTES - 1);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       held_q [2];
  logic [7:0]       held_d [2];
  logic [1:0]       held_cnt_q, held_cnt_d;

  logic [15:0]      crc_step;
  logic             in_hdr;
  logic             do_trl;
  logic [15:0]      trl_crc;
  logic             trl_flag;
  logic [CNT_W-1:0] k;
  res_list_t        res;

  assign in_hdr   = (pos_q != POS_DATA);
  assign crc_step = crc_add(crc_q, in_hdr ? item_i.data : held_q[0]);

  always_comb begin
    pos_d      = pos_q;
    crc_d      = crc_q;
    held_d     = held_q;
    held_cnt_d = held_cnt_q;
    do_trl     = 1'b0;
    trl_crc    = seed_i;
    trl_flag   = 1'b1;
    res        = '0;
    k          = '0;
    if (take_i) begin
      if (in_hdr) begin
        if (pos_q == '0 && item_i.last) begin
          // single byte packet: nothing goes out
          pos_d = '0;
          crc_d = seed_i;
        end else begin
          if (pos_q == '0) begin
            res.items[k] = '{SYNC_B0, 1'b0, 1'b0}; k = k + 1'b1;
            res.items[k] = '{SYNC_B1, 1'b0, 1'b0}; k = k + 1'b1;
            res.items[k] = '{SYNC_B2, 1'b0, 1'b0}; k = k + 1'b1;
            res.items[k] = '{SYNC_B3, 1'b0, 1'b0}; k = k + 1'b1;
          end
          res.items[k] = '{item_i.data, 1'b0, 1'b0}; k = k + 1'b1;
          crc_d = crc_step;
          if (item_i.last) begin
            do_trl = 1'b1;
          end else if (pos_q == POS_HLAST) begin
            res.items[k] = '{8'((crc_step & CRC_HI_MASK) >> 8), 1'b0, 1'b0};
            k = k + 1'b1;
            res.items[k] = '{8'(crc_step & CRC_LO_MASK), 1'b0, 1'b0};
            k = k + 1'b1;
            crc_d = seed_i;
            pos_d = POS_DATA;
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end
      end else begin
        if (held_cnt_q == 2'd2) begin
          res.items[k] = '{held_q[0], 1'b0, 1'b0}; k = k + 1'b1;
          crc_d     = crc_step;
          held_d[0] = held_q[1];
          held_d[1] = item_i.data;
        end else begin
          held_d[held_cnt_q[0]] = item_i.data;
          held_cnt_d = held_cnt_q + 1'b1;
        end
        if (item_i.last) begin
          do_trl = 1'b1;
          if (held_cnt_d == 2'd2) begin
            trl_crc  = crc_d;
            trl_flag = 1'b0;
          end
        end
      end
      if (do_trl) begin
        res.items[k] = '{8'((trl_crc & CRC_HI_MASK) >> 8), 1'b0, trl_flag}; k = k + 1'b1;
        res.items[k] = '{8'(trl_crc & CRC_LO_MASK), 1'b0, trl_flag};        k = k + 1'b1;
        res.items[k] = '{SYNC_B3, 1'b0, trl_flag};                          k = k + 1'b1;
        res.items[k] = '{SYNC_B2, 1'b0, trl_flag};                          k = k + 1'b1;
        res.items[k] = '{SYNC_B1, 1'b0, trl_flag};                          k = k + 1'b1;
        res.items[k] = '{SYNC_B0, 1'b1, trl_flag};                          k = k + 1'b1;
        // back to the idle packet state
        pos_d      = '0;
        crc_d      = seed_i;
        held_d[0]  = '0;
        held_d[1]  = '0;
        held_cnt_d = '0;
      end
    end
    res.cnt = k;
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      crc_q      <= SEED_RESET;
      held_q[0]  <= '0;
      held_q[1]  <= '0;
      held_cnt_q <= '0;
    end else begin
      pos_q      <= pos_d;
      crc_q      <= crc_d;
      held_q     <= held_d;
      held_cnt_q <= held_cnt_d;
    end
  end

endmodule

/* hdl/scfw_out_buf.sv */
module scfw_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  scfw_pkg::res_list_t res_i,
  output logic                load_ok_o,
  output logic                valid_o,
  input  logic                ready_i,
  output scfw_pkg::res_t      word_o
);
  import scfw_pkg::*;

  logic [CNT_W-1:0]   cnt_q;
  res_t [MAX_RES-1:0] ent_q;
  logic               pop;

  assign valid_o   = (cnt_q != '0);
  assign pop       = valid_o && ready_i;
  assign word_o    = ent_q[0];
  // free when empty, or once the word on show is the last one and leaves now
  assign load_ok_o = (cnt_q == '0) || (cnt_q == CNT_W'(1) && ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= res_i.cnt;
    end else if (pop) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= res_i.items;
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        ent_q[i] <= ent_q[i+1];
      end
    end
  end

endmodule

/* hdl/scfw_checker.sv */
module scfw_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);
  import scfw_pkg::*;

  // a stalled word stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("output word withdrawn while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      ($stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser)))
    else $error("output word changed while stalled");

  // frame closes on the final end sync byte
  a_last_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == SYNC_B0))
    else $error("frame end on a byte other than the closing sync");

  // a trailer is six words, so two frame ends never follow each other
  a_no_double_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !(m_axis_tvalid && m_axis_tlast))
    else $error("frame end directly after a frame end");

endmodule

bind sync_crc_frame_wrapper scfw_checker u_scfw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
